// ===== design/mfrc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the masked flow rule classifier
// no dependencies
package mfrc_pkg;

    localparam int RULE_SLOTS_DEF   = 256;
    localparam int GROUP_COUNT_DEF  = 256;
    localparam int MAX_JUMPS_DEF    = 8;
    localparam int ACTION_SLOTS_DEF = 3;

    localparam int WORDS_PER_RULE = 9;
    localparam int ROW_W          = WORDS_PER_RULE * 64;

    localparam logic [3:0]  WI_CTRL   = 4'd7;
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_UDP = 8'h11;
    localparam logic [13:0] MIN_FRAME = 14'd34;
    localparam logic [4:0]  DECAP_MAX = 5'd31;

    typedef enum logic [1:0] {
        CMD_CLASSIFY = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_INVAL    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_MARK  = 2'd1,
        ACT_DECAP = 2'd2,
        ACT_JUMP  = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_SCAN,
        ST_EVAL,
        ST_RESOLVE,
        ST_ACT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] ip_source;
        logic [31:0] ip_destination;
        logic [7:0]  ip_protocol;
        logic [31:0] l4_ports;
    } t_pkt;

    typedef struct packed {
        logic        hit;
        logic [11:0] pri;
    } t_match;

endpackage

// ===== design/mfrc_rule_mem.sv =====
`timescale 1ns / 1ps
// rule store: one row of nine 64-bit words per slot, registered read
// depends on mfrc_pkg
module mfrc_rule_mem #(
    parameter int RULE_SLOTS = mfrc_pkg::RULE_SLOTS_DEF,
    parameter int SW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [SW-1:0]              i_rd_addr,
    output logic [mfrc_pkg::ROW_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [SW-1:0]              i_wr_addr,
    input  logic [mfrc_pkg::ROW_W-1:0] i_wr_data
);
    import mfrc_pkg::*;

    logic [ROW_W-1:0] mem [RULE_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end
endmodule

// ===== design/mfrc_match.sv =====
`timescale 1ns / 1ps
// masked compare of one rule row against the packet header
// depends on mfrc_pkg
module mfrc_match #(
    parameter int GROUP_COUNT = mfrc_pkg::GROUP_COUNT_DEF
) (
    input  logic [mfrc_pkg::ROW_W-1:0] i_row,
    input  logic                       i_valid,
    input  logic [7:0]                 i_group,
    input  mfrc_pkg::t_pkt             i_pkt,
    output mfrc_pkg::t_match           o_match
);
    import mfrc_pkg::*;

    logic [63:0] w [WORDS_PER_RULE];
    logic [7:0]  proto;
    logic [7:0]  grp;
    logic        hdr_ok;
    logic        proto_ok;

    always_comb begin
        for (int i = 0; i < WORDS_PER_RULE; i++) begin
            w[i] = i_row[64*i +: 64];
        end
        proto = w[7][15:8];
        grp   = w[7][23:16];
        hdr_ok = (((w[0][47:0] ^ i_pkt.dst_mac) & w[1][47:0]) == 48'd0)
              && (((w[2][47:0] ^ i_pkt.src_mac) & w[3][47:0]) == 48'd0)
              && (((w[4][31:0] ^ i_pkt.ip_source) & w[5][31:0]) == 32'd0)
              && (((w[4][63:32] ^ i_pkt.ip_destination) & w[5][63:32]) == 32'd0);
        // proto zero is a wildcard, ports only count for udp
        proto_ok = (proto == 8'd0)
                || ((proto == i_pkt.ip_protocol)
                    && ((proto != PROTO_UDP)
                        || (((w[6][31:0] ^ i_pkt.l4_ports) & w[6][63:32]) == 32'd0)));
        o_match.hit = i_valid && (grp == i_group) && ({1'b0, grp} < 9'(GROUP_COUNT))
                   && hdr_ok && proto_ok;
        o_match.pri = w[7][63:52];
    end
endmodule

// ===== design/masked_flow_rule_classifier.sv =====
`timescale 1ns / 1ps
// top level: command decode, rule scan sequencer, action walk
// depends on mfrc_pkg, mfrc_rule_mem, mfrc_match
//
// channel   direction  handshake                 payload
// command   in         start & !busy             i_command .. i_frame_length
// result    out        o_valid, one cycle        o_matched .. o_jump_limit_hit
//
// write word: read row, merge and write back, result
// invalidate and ignored commands: straight to the result
// classify: per group visited, a scan of every slot (one rule row read per cycle from
// the rule memory port), evaluate, resolve, then actions if found; at most MAX_JUMPS+1 groups
// reset clears the valid bits and control at once; rule words are undefined until written
// the receiver cannot stall: each result word shows for one cycle
module masked_flow_rule_classifier #(
    parameter int RULE_SLOTS   = mfrc_pkg::RULE_SLOTS_DEF,
    parameter int GROUP_COUNT  = mfrc_pkg::GROUP_COUNT_DEF,
    parameter int MAX_JUMPS    = mfrc_pkg::MAX_JUMPS_DEF,
    parameter int ACTION_SLOTS = mfrc_pkg::ACTION_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_slot,
    input  logic [3:0]  i_word_index,
    input  logic [63:0] i_word_data,
    input  logic [47:0] i_dst_mac,
    input  logic [47:0] i_src_mac,
    input  logic [15:0] i_ether_type,
    input  logic [31:0] i_ip_source,
    input  logic [31:0] i_ip_destination,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_l4_ports,
    input  logic [13:0] i_frame_length,
    output logic        o_valid,
    output logic        o_matched,
    output logic        o_mark_valid,
    output logic [31:0] o_mark_value,
    output logic [4:0]  o_decap_count,
    output logic [7:0]  o_final_group,
    output logic        o_jump_limit_hit
);
    import mfrc_pkg::*;

    localparam int SW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int JW = $clog2(MAX_JUMPS + 1);
    localparam int KW = $clog2(ACTION_SLOTS + 1);

    t_state r_state, n_state;

    // latched command word
    t_pkt        r_pkt, n_pkt;
    logic [SW-1:0] r_addr, n_addr;
    logic [3:0]  r_widx, n_widx;
    logic [63:0] r_data, n_data;

    // scan and walk state
    logic [SW-1:0] r_cnt, n_cnt;
    logic [7:0]  r_group, n_group;
    logic [JW-1:0] r_jumps, n_jumps;
    logic [KW-1:0] r_k, n_k;
    logic        r_pend;
    logic        r_pend_valid;
    logic        r_found, n_found;
    logic [11:0] r_best_pri, n_best_pri;
    logic [63:0] r_best_ctl, n_best_ctl;
    logic [31:0] r_best_mark, n_best_mark;

    // result word
    logic        r_matched, n_matched;
    logic        r_mark_valid, n_mark_valid;
    logic [31:0] r_mark_value, n_mark_value;
    logic [4:0]  r_decap, n_decap;
    logic [7:0]  r_final, n_final;
    logic        r_limit, n_limit;

    logic        r_valid_bit [RULE_SLOTS];

    logic             mem_rd_en;
    logic [SW-1:0]    mem_rd_addr;
    logic [ROW_W-1:0] mem_rd_data;
    logic             mem_wr_en;
    logic [ROW_W-1:0] mem_wr_data;
    t_match           match;

    logic    accept;
    logic    slot_ok;
    logic    set_valid, clr_valid;
    t_act    act;

    mfrc_rule_mem #(.RULE_SLOTS(RULE_SLOTS), .SW(SW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (mem_wr_data)
    );

    mfrc_match #(.GROUP_COUNT(GROUP_COUNT)) u_match (
        .i_row   (mem_rd_data),
        .i_valid (r_pend && r_pend_valid),
        .i_group (r_group),
        .i_pkt   (r_pkt),
        .o_match (match)
    );

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign slot_ok = (32'(i_slot) < RULE_SLOTS);

    assign mem_rd_en   = (r_state == ST_SCAN) || (r_state == ST_WR_RD);
    assign mem_rd_addr = (r_state == ST_SCAN) ? r_cnt : r_addr;
    assign mem_wr_en   = (r_state == ST_WR_WB);

    // merge the new word into the row read back
    always_comb begin
        for (int i = 0; i < WORDS_PER_RULE; i++) begin
            mem_wr_data[64*i +: 64] = (r_widx == 4'(i)) ? r_data : mem_rd_data[64*i +: 64];
        end
    end

    assign act = t_act'(r_best_ctl[32 + 2*r_k +: 2]);

    always_comb begin
        n_state      = r_state;
        n_pkt        = r_pkt;
        n_addr       = r_addr;
        n_widx       = r_widx;
        n_data       = r_data;
        n_cnt        = r_cnt;
        n_group      = r_group;
        n_jumps      = r_jumps;
        n_k          = r_k;
        n_found      = r_found;
        n_best_pri   = r_best_pri;
        n_best_ctl   = r_best_ctl;
        n_best_mark  = r_best_mark;
        n_matched    = r_matched;
        n_mark_valid = r_mark_valid;
        n_mark_value = r_mark_value;
        n_decap      = r_decap;
        n_final      = r_final;
        n_limit      = r_limit;
        set_valid    = 1'b0;
        clr_valid    = 1'b0;

        // winner update from the row that came back this cycle
        if (match.hit && (!r_found || (match.pri > r_best_pri))) begin
            n_found     = 1'b1;
            n_best_pri  = match.pri;
            n_best_ctl  = mem_rd_data[64*7 +: 64];
            n_best_mark = mem_rd_data[64*8 +: 32];
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pkt.dst_mac        = i_dst_mac;
                    n_pkt.src_mac        = i_src_mac;
                    n_pkt.ip_source      = i_ip_source;
                    n_pkt.ip_destination = i_ip_destination;
                    n_pkt.ip_protocol    = i_ip_protocol;
                    n_pkt.l4_ports       = i_l4_ports;
                    n_addr       = SW'(i_slot);
                    n_widx       = i_word_index;
                    n_data       = i_word_data;
                    n_matched    = 1'b0;
                    n_mark_valid = 1'b0;
                    n_mark_value = 32'd0;
                    n_decap      = 5'd0;
                    n_final      = 8'd0;
                    n_limit      = 1'b0;
                    n_group      = 8'd0;
                    n_jumps      = '0;
                    n_cnt        = '0;
                    n_found      = 1'b0;
                    n_state      = ST_FIN;
                    unique case (i_command)
                        CMD_WRITE: begin
                            if (slot_ok && (i_word_index < 4'(WORDS_PER_RULE))) begin
                                n_state = ST_WR_RD;
                            end
                        end
                        CMD_INVAL: begin
                            clr_valid = slot_ok;
                        end
                        CMD_CLASSIFY: begin
                            if ((i_frame_length >= MIN_FRAME) && (i_ether_type == ETH_IPV4)) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WR_RD: begin
                n_state = ST_WR_WB;
            end
            ST_WR_WB: begin
                set_valid = (r_widx == WI_CTRL);
                n_state   = ST_FIN;
            end
            ST_SCAN: begin
                n_final = r_group;
                n_cnt   = r_cnt + SW'(1);
                if (r_cnt == SW'(RULE_SLOTS - 1)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                n_k = '0;
                if (!r_found) begin
                    n_state = ST_FIN;
                end else begin
                    if (r_group == 8'd0) begin
                        n_matched = 1'b1;
                    end
                    n_state = ST_ACT;
                end
            end
            ST_ACT: begin
                n_k = r_k + KW'(1);
                if (r_k == KW'(ACTION_SLOTS - 1)) begin
                    n_state = ST_FIN;
                end
                unique case (act)
                    ACT_MARK: begin
                        if (r_best_mark != 32'd0) begin
                            n_mark_valid = 1'b1;
                            n_mark_value = r_best_mark;
                        end
                    end
                    ACT_DECAP: begin
                        if (r_decap < DECAP_MAX) begin
                            n_decap = r_decap + 5'd1;
                        end
                    end
                    ACT_JUMP: begin
                        // a jump ends the list whether taken or cut
                        if (r_jumps >= JW'(MAX_JUMPS)) begin
                            n_limit = 1'b1;
                            n_state = ST_FIN;
                        end else begin
                            n_jumps = r_jumps + JW'(1);
                            n_group = r_best_ctl[31:24];
                            n_cnt   = '0;
                            n_found = 1'b0;
                            n_state = ST_SCAN;
                        end
                    end
                    ACT_NONE: begin
                    end
                endcase
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_jumps <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == ST_SCAN);
            r_found <= n_found;
            r_jumps <= n_jumps;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_valid <= r_valid_bit[r_cnt];
        r_pkt        <= n_pkt;
        r_addr       <= n_addr;
        r_widx       <= n_widx;
        r_data       <= n_data;
        r_group      <= n_group;
        r_best_pri   <= n_best_pri;
        r_best_ctl   <= n_best_ctl;
        r_best_mark  <= n_best_mark;
        r_matched    <= n_matched;
        r_mark_valid <= n_mark_valid;
        r_mark_value <= n_mark_value;
        r_decap      <= n_decap;
        r_final      <= n_final;
        r_limit      <= n_limit;
    end

    // valid bits live in flops so reset clears them at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RULE_SLOTS; i++) begin
                r_valid_bit[i] <= 1'b0;
            end
        end else if (clr_valid) begin
            r_valid_bit[SW'(i_slot)] <= 1'b0;
        end else if (set_valid) begin
            r_valid_bit[r_addr] <= r_data[0];
        end
    end

    assign o_valid          = (r_state == ST_FIN);
    assign o_matched        = r_matched;
    assign o_mark_valid     = r_mark_valid;
    assign o_mark_value     = r_mark_value;
    assign o_decap_count    = r_decap;
    assign o_final_group    = r_final;
    assign o_jump_limit_hit = r_limit;

    a_one_cycle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted command did not raise busy");

    a_jump_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jumps <= JW'(MAX_JUMPS))
        else $error("jump count beyond bound");

    a_limit_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_jump_limit_hit) |-> (r_jumps == JW'(MAX_JUMPS)))
        else $error("limit flag without the bound reached");

    a_act_has_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACT) |-> r_found)
        else $error("action walk without a winning rule");
endmodule
